// ===== rtl/qte_pkg.sv =====
// Shared types, constants and angle table for the quaternion to Euler angle converter.
// No dependencies; every other file in rtl/ imports it.
package qte_pkg;

  // CORDIC datapath widths: vector components and angle accumulator
  localparam int unsigned CW = 40;
  localparam int unsigned ZW = 34;
  // width of the two atan2 numerators that can exceed 32 bits
  localparam int unsigned TW = 34;

  localparam logic signed [63:0]   ONE_Q60 = 64'sd1 << 60;
  localparam logic signed [ZW-1:0] PI_Q29  = 34'sd1686629713;
  localparam logic signed [ZW-1:0] HPI_Q29 = 34'sd843314857;

  // side data around the first square root
  typedef struct packed {
    logic               inv;
    logic signed [31:0] t1;
    logic signed [31:0] t4;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [63:0] xy;
    logic signed [63:0] yz;
    logic signed [63:0] zx;
  } s1_side_t;

  // side data around the second square root
  typedef struct packed {
    logic                 inv;
    logic signed [TW-1:0] t0;
    logic signed [TW-1:0] t3;
    logic signed [31:0]   t1;
    logic signed [31:0]   t2;
    logic signed [31:0]   t4;
  } s2_side_t;

  // atan(2^-i) in Q3.29, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_step(input int unsigned i);
    logic signed [ZW-1:0] v;
    case (i)
      0:       v = 34'sd421657428;
      1:       v = 34'sd248918915;
      2:       v = 34'sd131521918;
      3:       v = 34'sd66762579;
      4:       v = 34'sd33510843;
      5:       v = 34'sd16771758;
      6:       v = 34'sd8387925;
      7:       v = 34'sd4194219;
      8:       v = 34'sd2097141;
      9:       v = 34'sd1048575;
      10:      v = 34'sd524288;
      default: v = (i <= 29) ? (34'sd1 <<< (29 - i)) : '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [ZW-1:0] sat_angle(input logic signed [ZW-1:0] a,
                                                     input logic signed [ZW-1:0] lim);
    logic signed [ZW-1:0] r;
    if (a > lim) begin
      r = lim;
    end else if (a < -lim) begin
      r = -lim;
    end else begin
      r = a;
    end
    return r;
  endfunction

endpackage

// ===== rtl/qte_sqrt.sv =====
// Pipelined 31-step restoring floor square root, one result bit per stage.
// Carries an opaque side word alongside each item. Depends on qte_pkg.
module qte_sqrt #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [60:0]       rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [30:0]       root_o,
  output logic [SIDE_W-1:0] side_o
);
  import qte_pkg::*;

  localparam int unsigned NS = 31;

  logic [NS-1:0]     vld_q;
  logic [60:0]       rem_q  [NS];
  logic [61:0]       res_q  [NS];
  logic [SIDE_W-1:0] side_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam logic [61:0] BIT = 62'd1 << (60 - 2 * k);
    logic [60:0]       rem_in;
    logic [61:0]       res_in;
    logic              vld_in;
    logic [SIDE_W-1:0] side_in;
    logic [61:0]       trial;
    logic              take;

    if (k == 0) begin : g_first
      assign rem_in  = rad_i;
      assign res_in  = '0;
      assign vld_in  = vld_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign res_in  = res_q[k-1];
      assign vld_in  = vld_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = res_in + BIT;
    assign take  = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? (rem_in - trial[60:0]) : rem_in;
        res_q[k]  <= take ? ((res_in >> 1) + BIT) : (res_in >> 1);
        side_q[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[NS-1];
  assign root_o = res_q[NS-1][30:0];
  assign side_o = side_q[NS-1];

endmodule

// ===== rtl/qte_cordic.sv =====
// Pipelined vectoring CORDIC, one rotation per stage, on several lanes at once.
// Gives atan2(y, x) in Q3.29 per lane. Depends on qte_pkg.
module qte_cordic #(
  parameter int unsigned STEPS = 30,
  parameter int unsigned NL    = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         vld_i,
  input  logic                         flag_i,
  input  logic signed [qte_pkg::CW-1:0] y_i   [NL],
  input  logic signed [qte_pkg::CW-1:0] x_i   [NL],
  output logic                         vld_o,
  output logic                         flag_o,
  output logic signed [qte_pkg::ZW-1:0] ang_o [NL]
);
  import qte_pkg::*;

  logic [STEPS:0]       vld_q;
  logic [STEPS:0]       flag_q;
  logic [NL-1:0]        zero_q [STEPS+1];
  logic signed [CW-1:0] x_q    [STEPS+1][NL];
  logic signed [CW-1:0] y_q    [STEPS+1][NL];
  logic signed [ZW-1:0] z_q    [STEPS+1][NL];

  // quarter-turn pre-rotation puts x in the right half plane
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flag_q[0] <= flag_i;
      for (int l = 0; l < NL; l++) begin
        zero_q[0][l] <= (x_i[l] == '0) && (y_i[l] == '0);
        if (x_i[l][CW-1]) begin
          if (!y_i[l][CW-1]) begin
            x_q[0][l] <= y_i[l];
            y_q[0][l] <= -x_i[l];
            z_q[0][l] <= HPI_Q29;
          end else begin
            x_q[0][l] <= -y_i[l];
            y_q[0][l] <= x_i[l];
            z_q[0][l] <= -HPI_Q29;
          end
        end else begin
          x_q[0][l] <= x_i[l];
          y_q[0][l] <= y_i[l];
          z_q[0][l] <= '0;
        end
      end
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic signed [ZW-1:0] ANG = atan_step(k);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flag_q[k+1] <= flag_q[k];
        zero_q[k+1] <= zero_q[k];
        for (int l = 0; l < NL; l++) begin
          // rotate toward the x axis
          if (!y_q[k][l][CW-1]) begin
            x_q[k+1][l] <= x_q[k][l] + (y_q[k][l] >>> k);
            y_q[k+1][l] <= y_q[k][l] - (x_q[k][l] >>> k);
            z_q[k+1][l] <= z_q[k][l] + ANG;
          end else begin
            x_q[k+1][l] <= x_q[k][l] - (y_q[k][l] >>> k);
            y_q[k+1][l] <= y_q[k][l] + (x_q[k][l] >>> k);
            z_q[k+1][l] <= z_q[k][l] - ANG;
          end
        end
      end
    end
  end

  assign vld_o  = vld_q[STEPS];
  assign flag_o = flag_q[STEPS];

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      ang_o[l] = zero_q[STEPS][l] ? '0 : z_q[STEPS][l];
    end
  end

endmodule

// ===== rtl/quaternion_to_euler_angles.sv =====
// Quaternion (x, y, z parts, Q2.30) to ZYX Euler angles (Q3.29 radians). One item enters
// per clock and one result leaves per clock unless stalled; each passes two 31-stage square root
// pipelines and an atan2 pipeline of CORDIC_STEPS rotation stages. When the squared norm
// of the input exceeds one, invalid_input_o is set with roll pi, pitch 0, yaw 0. A full
// output register left unread stalls the pipeline. Depends on qte_pkg, qte_sqrt, qte_cordic.
module quaternion_to_euler_angles #(
  parameter int unsigned CORDIC_STEPS = 30
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] quat_x_i,
  input  logic signed [31:0] quat_y_i,
  input  logic signed [31:0] quat_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] roll_angle_o,
  output logic signed [30:0] pitch_angle_o,
  output logic signed [31:0] yaw_angle_o,
  output logic               invalid_input_o
);
  import qte_pkg::*;

  logic en;
  logic out_vld_q;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // stage 1: squares and cross products
  logic               vld1_q;
  logic signed [31:0] x1_q, y1_q, z1_q;
  logic signed [63:0] xx1_q, yy1_q, zz1_q, xy1_q, yz1_q, zx1_q;

  // stage 2: sums of squares
  logic               vld2_q;
  logic signed [31:0] x2_q, y2_q, z2_q;
  logic signed [63:0] xy2_q, yz2_q, zx2_q;
  logic [63:0]        s2_q;
  logic signed [63:0] sxy2_q, syz2_q;

  // stage 3: norm check, radicand, denominators
  logic        vld3_q;
  logic [60:0] rad3_q;
  s1_side_t    side3_q, side3_d;
  logic [63:0] rad3_full;
  logic signed [63:0] d1, d4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en) begin
      vld1_q <= in_valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_comb begin
    rad3_full   = 64'(ONE_Q60) - s2_q;
    d1          = ONE_Q60 - (sxy2_q <<< 1);
    d4          = ONE_Q60 - (syz2_q <<< 1);
    side3_d.inv = s2_q > 64'(ONE_Q60);
    side3_d.t1  = d1[61:30];
    side3_d.t4  = d4[61:30];
    side3_d.x   = x2_q;
    side3_d.y   = y2_q;
    side3_d.z   = z2_q;
    side3_d.xy  = xy2_q;
    side3_d.yz  = yz2_q;
    side3_d.zx  = zx2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q   <= quat_x_i;
      y1_q   <= quat_y_i;
      z1_q   <= quat_z_i;
      xx1_q  <= quat_x_i * quat_x_i;
      yy1_q  <= quat_y_i * quat_y_i;
      zz1_q  <= quat_z_i * quat_z_i;
      xy1_q  <= quat_x_i * quat_y_i;
      yz1_q  <= quat_y_i * quat_z_i;
      zx1_q  <= quat_z_i * quat_x_i;

      x2_q   <= x1_q;
      y2_q   <= y1_q;
      z2_q   <= z1_q;
      xy2_q  <= xy1_q;
      yz2_q  <= yz1_q;
      zx2_q  <= zx1_q;
      s2_q   <= xx1_q + yy1_q + zz1_q;
      sxy2_q <= xx1_q + yy1_q;
      syz2_q <= yy1_q + zz1_q;

      rad3_q  <= rad3_full[60:0];
      side3_q <= side3_d;
    end
  end

  // scalar part w
  logic        vld_w;
  logic [30:0] w_root;
  s1_side_t    side_w;

  qte_sqrt #(
    .SIDE_W($bits(s1_side_t))
  ) u_sqrt_w (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (vld3_q),
    .rad_i (rad3_q),
    .side_i(side3_q),
    .vld_o (vld_w),
    .root_o(w_root),
    .side_o(side_w)
  );

  // stage 4: products with w
  logic               vld4_q;
  logic signed [63:0] wx4_q, wy4_q, wz4_q;
  s1_side_t           side4_q;
  logic signed [31:0] ws;

  assign ws = signed'({1'b0, w_root});

  // stage 5: numerator sums
  logic               vld5_q;
  logic signed [63:0] a0_5_q, a2_5_q, a3_5_q;
  s1_side_t           side5_q;

  // stage 6: scale to Q.30, clamp the pitch term
  logic               vld6_q;
  s2_side_t           side6_q, side6_d;
  logic signed [63:0] c2, c2_clamped;

  always_comb begin
    c2 = a2_5_q <<< 1;
    if (c2 > ONE_Q60) begin
      c2_clamped = ONE_Q60;
    end else if (c2 < -ONE_Q60) begin
      c2_clamped = -ONE_Q60;
    end else begin
      c2_clamped = c2;
    end
    side6_d.inv = side5_q.inv;
    side6_d.t0  = a0_5_q[62:29];
    side6_d.t3  = a3_5_q[62:29];
    side6_d.t1  = side5_q.t1;
    side6_d.t2  = c2_clamped[61:30];
    side6_d.t4  = side5_q.t4;
  end

  // stage 7: pitch term squared; stage 8: radicand for the pitch cosine
  logic               vld7_q, vld8_q;
  logic signed [63:0] p7_q;
  s2_side_t           side7_q, side8_q;
  logic [60:0]        rad8_q;
  logic signed [63:0] rad8_full;

  assign rad8_full = ONE_Q60 - p7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld4_q <= 1'b0;
      vld5_q <= 1'b0;
      vld6_q <= 1'b0;
      vld7_q <= 1'b0;
      vld8_q <= 1'b0;
    end else if (en) begin
      vld4_q <= vld_w;
      vld5_q <= vld4_q;
      vld6_q <= vld5_q;
      vld7_q <= vld6_q;
      vld8_q <= vld7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wx4_q   <= ws * side_w.x;
      wy4_q   <= ws * side_w.y;
      wz4_q   <= ws * side_w.z;
      side4_q <= side_w;

      a0_5_q  <= wx4_q + side4_q.yz;
      a2_5_q  <= wy4_q - side4_q.zx;
      a3_5_q  <= wz4_q + side4_q.xy;
      side5_q <= side4_q;

      side6_q <= side6_d;

      p7_q    <= side6_q.t2 * side6_q.t2;
      side7_q <= side6_q;

      rad8_q  <= rad8_full[60:0];
      side8_q <= side7_q;
    end
  end

  // pitch cosine
  logic        vld_c;
  logic [30:0] c_root;
  s2_side_t    side_c;

  qte_sqrt #(
    .SIDE_W($bits(s2_side_t))
  ) u_sqrt_c (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (vld8_q),
    .rad_i (rad8_q),
    .side_i(side8_q),
    .vld_o (vld_c),
    .root_o(c_root),
    .side_o(side_c)
  );

  // three atan2 lanes: roll, pitch, yaw
  logic signed [CW-1:0] cy [3];
  logic signed [CW-1:0] cx [3];
  logic signed [ZW-1:0] ang [3];
  logic                 vld_a;
  logic                 inv_a;

  always_comb begin
    cy[0] = CW'(side_c.t0);
    cx[0] = CW'(side_c.t1);
    cy[1] = CW'(side_c.t2);
    cx[1] = CW'(signed'({1'b0, c_root}));
    cy[2] = CW'(side_c.t3);
    cx[2] = CW'(side_c.t4);
  end

  qte_cordic #(
    .STEPS(CORDIC_STEPS),
    .NL   (3)
  ) u_cordic (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (vld_c),
    .flag_i(side_c.inv),
    .y_i   (cy),
    .x_i   (cx),
    .vld_o (vld_a),
    .flag_o(inv_a),
    .ang_o (ang)
  );

  // output register
  logic signed [ZW-1:0] roll_sat, pitch_sat, yaw_sat;
  logic signed [31:0]   roll_q, yaw_q;
  logic signed [30:0]   pitch_q;
  logic                 inv_q;

  assign roll_sat  = inv_a ? PI_Q29 : sat_angle(ang[0], PI_Q29);
  assign pitch_sat = inv_a ? '0 : sat_angle(ang[1], HPI_Q29);
  assign yaw_sat   = inv_a ? '0 : sat_angle(ang[2], PI_Q29);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_a;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q  <= roll_sat[31:0];
      pitch_q <= pitch_sat[30:0];
      yaw_q   <= yaw_sat[31:0];
      inv_q   <= inv_a;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign roll_angle_o    = roll_q;
  assign pitch_angle_o   = pitch_q;
  assign yaw_angle_o     = yaw_q;
  assign invalid_input_o = inv_q;

`ifndef SYNTHESIS
  a_invalid_defaults: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invalid_input_o |->
      roll_angle_o == 32'(PI_Q29) && pitch_angle_o == '0 && yaw_angle_o == '0)
    else $error("invalid item without default angles");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ZW'(pitch_angle_o) <= HPI_Q29 && ZW'(pitch_angle_o) >= -HPI_Q29)
    else $error("pitch beyond half pi");

  a_roll_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ZW'(roll_angle_o) <= PI_Q29 && ZW'(roll_angle_o) >= -PI_Q29
      && ZW'(yaw_angle_o) <= PI_Q29 && ZW'(yaw_angle_o) >= -PI_Q29)
    else $error("roll or yaw beyond pi");
`endif

endmodule
